[hdl/tmra_pkg.sv]
// Shared constants and helpers for the Reinhard / ACES tone mapper.
// Used by tmra_chan and pixel_tonemap_reinhard_aces.
package tmra_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic CFG_CURVE_MODE = 1'b0;
  localparam logic CFG_EXPOSURE   = 1'b1;

  localparam logic MODE_REINHARD = 1'b0;
  localparam logic MODE_ACES     = 1'b1;

  localparam logic [15:0] EXPOSURE_RESET = 16'd256;

  // Fixed-point constant n/100 rounded half up to f fractional bits.
  function automatic longint fx_const(input int n, input int f);
    fx_const = ((longint'(n) <<< f) + 64'd50) / 64'd100;
  endfunction

  // Folding stages of the divide by 255 that gives the exposed channel value.
  // Each stage takes about seven bits off the remainder until it is below 510.
  function automatic int h_steps(input int f);
    h_steps = (f + 23) / 7;
  endfunction

  // Pipeline depth from pixel request to result for a given precision.
  function automatic int pipe_latency(input int f);
    pipe_latency = f + 9 + h_steps(f);
  endfunction

endpackage

[hdl/pixel_tonemap_reinhard_aces.sv]
// Tone mapper for packed RGB pixels: each channel is scaled by a Q8.8 exposure and
// passed through the Reinhard curve or the fitted ACES curve, then rounded to 8 bits.
// One pixel is taken per clock while the output is not stalled; most of the pipeline
// is the bit-per-stage curve divider of each channel, with folding stages for the
// divide by 255 of the exposure. A stalled output holds the whole pipeline.
// The alpha byte of every result is 0xFF.
// Depends on tmra_pkg, tmra_chan and tmra_div.
module pixel_tonemap_reinhard_aces import tmra_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_in: blue 7:0, green 15:8, red 23:16, unused 31:24
  input  logic        s_tlast,   // frame_last_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_out: blue 7:0, green 15:8, red 23:16, alpha 31:24
  output logic        m_tlast,   // frame_last_out
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int LAT = pipe_latency(FRAC_BITS);

  logic        curve_mode;
  logic [15:0] exposure_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode    <= MODE_REINHARD;
      exposure_gain <= EXPOSURE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CURVE_MODE: curve_mode    <= cfg_wdata[0];
        CFG_EXPOSURE:   exposure_gain <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  logic           en;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] lst;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) lst <= {lst[LAT-2:0], s_tlast};
  end

  logic [7:0] ch_out [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    tmra_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
      .clk           (clk),
      .en            (en),
      .curve_mode    (curve_mode),
      .exposure_gain (exposure_gain),
      .x             (s_tdata[8*c +: 8]),
      .y             (ch_out[c])
    );
  end

  assign m_tvalid = vld[LAT-1];
  assign m_tlast  = lst[LAT-1];
  assign m_tdata  = {8'hFF, ch_out[2], ch_out[1], ch_out[0]};

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result shown straight after reset");

  a_rise_needs_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(en))
    else $error("result appeared while the pipeline was held");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] == 8'hFF)
    else $error("alpha byte not opaque");

endmodule

[hdl/tmra_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the quotient must be known to fit in QW bits.
module tmra_div #(
  parameter int DW = 33,
  parameter int VW = 8,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quot
);

  logic [VW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [VW-1:0] dv   [QW+1];
  logic [QW-1:0] q    [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= VW'(dividend[DW-1:QW]);
      low[0] <= dividend[QW-1:0];
      dv[0]  <= divisor;
      q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [VW:0] trial;
    logic [VW:0] diff;
    assign trial = {rem[k], low[k][QW-1]};
    assign diff  = trial - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, dv[k]}) begin
          rem[k+1] <= diff[VW-1:0];
          q[k+1]   <= {q[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[VW-1:0];
          q[k+1]   <= {q[k][QW-2:0], 1'b0};
        end
        low[k+1] <= {low[k][QW-2:0], 1'b0};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quot = q[QW];

endmodule

[hdl/tmra_chan.sv]
// One colour channel of the tone mapper: exposure, curve and rounding to 8 bits.
// Depends on tmra_pkg and tmra_div.
module tmra_chan import tmra_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic        curve_mode,
  input  logic [15:0] exposure_gain,
  input  logic [7:0]  x,
  output logic [7:0]  y
);

  localparam int F    = FRAC_BITS;
  localparam int N1W  = 17 + F;
  localparam int HW   = F + 9;
  localparam int HCW  = F + 5;
  localparam int TW   = F + 6;
  localparam int DW2  = 2 * F + 10;
  localparam int VW2  = F + 10;
  localparam int QW2  = F + 2;
  localparam int NST  = h_steps(F);

  localparam logic [F+1:0] ACES_A = (F+2)'(fx_const(251, F));
  localparam logic [F+1:0] ACES_B = (F+2)'(fx_const(3, F));
  localparam logic [F+1:0] ACES_C = (F+2)'(fx_const(243, F));
  localparam logic [F+1:0] ACES_D = (F+2)'(fx_const(59, F));
  localparam logic [F+1:0] ACES_E = (F+2)'(fx_const(14, F));
  localparam logic [HW-1:0]  H_LIMIT = HW'(1) << (F + 4);
  localparam logic [VW2-1:0] ONE_V   = VW2'(1) << F;
  localparam logic [QW2-1:0] ONE_Q   = QW2'(1) << F;

  // Exposure product and the rounding offset before the divide by 255*256.
  logic [23:0]   prod;
  logic [N1W-1:0] n1;
  logic [F+24:0] n1_sum;

  always_ff @(posedge clk) begin
    if (en) prod <= 24'(x) * 24'(exposure_gain);
  end

  assign n1_sum = {1'b0, prod, {F{1'b0}}} + (F+25)'(32640);

  always_ff @(posedge clk) begin
    if (en) n1 <= n1_sum[F+24:8];
  end

  // Divide by 255: since 256 = 255 + 1, each stage adds the bits above the low byte
  // to the quotient and folds them back into the remainder. What is left at the end
  // is below 510, so one compare finishes the quotient.
  logic [N1W-1:0] dr [NST];
  logic [HW-1:0]  dq [NST];

  for (genvar k = 0; k < NST; k++) begin : g_d255
    logic [N1W-1:0] r_in;
    logic [HW-1:0]  q_in;
    if (k == 0) begin : g_first
      assign r_in = n1;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = dr[k-1];
      assign q_in = dq[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k] <= N1W'(r_in[N1W-1:8]) + N1W'(r_in[7:0]);
        dq[k] <= q_in + r_in[N1W-1:8];
      end
    end
  end

  logic [HW-1:0] h;

  always_ff @(posedge clk) begin
    if (en) h <= dq[NST-1] + HW'(dr[NST-1] >= N1W'(255));
  end

  // First ACES products, on h limited to 16.0.
  logic [HCW-1:0] hc_c;
  logic [2*F+6:0] pa, pc;
  logic [HCW-1:0] hc_a;
  logic [HW-1:0]  h_a;
  logic [TW-1:0]  ta, tc;

  assign hc_c = (h > H_LIMIT) ? H_LIMIT[HCW-1:0] : h[HCW-1:0];
  assign pa   = hc_c * ACES_A;
  assign pc   = hc_c * ACES_C;

  always_ff @(posedge clk) begin
    if (en) begin
      hc_a <= hc_c;
      h_a  <= h;
      ta   <= TW'(pa >> F) + TW'(ACES_B);
      tc   <= TW'(pc >> F) + TW'(ACES_D);
    end
  end

  // Second products, then the curve selects what goes to the divider.
  logic [2*F+10:0] pn, pd;
  logic [DW2-1:0]  dvd;
  logic [VW2-1:0]  dvs;

  assign pn = hc_a * ta;
  assign pd = hc_a * tc;

  always_ff @(posedge clk) begin
    if (en) begin
      if (curve_mode == MODE_ACES) begin
        dvd <= {VW2'(pn >> F), {F{1'b0}}};
        dvs <= VW2'(pd >> F) + VW2'(ACES_E);
      end else begin
        dvd <= {1'b0, h_a, {F{1'b0}}};
        dvs <= VW2'(h_a) + ONE_V;
      end
    end
  end

  logic [QW2-1:0] yq;
  tmra_div #(.DW(DW2), .VW(VW2), .QW(QW2)) u_cdiv (
    .clk      (clk),
    .en       (en),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (yq)
  );

  // Clamp to 1.0 and scale to 8 bits with rounding.
  logic [F:0]   yc;
  logic [F+8:0] ys;
  logic [8:0]   o;

  assign yc = (yq > ONE_Q) ? ONE_Q[F:0] : yq[F:0];
  assign ys = (F+9)'(yc) * (F+9)'(255) + ((F+9)'(1) << (F - 1));
  assign o  = ys[F+8:F];

  always_ff @(posedge clk) begin
    if (en) y <= (o > 9'd255) ? 8'd255 : o[7:0];
  end

endmodule
